// ===== rtl/radial_spotlight_luminance_assert.svh =====
// assertion macros for the spotlight luminance block
// used by rtl modules through a plain include, no other dependencies
`ifndef RADIAL_SPOTLIGHT_LUMINANCE_ASSERT_SVH
`define RADIAL_SPOTLIGHT_LUMINANCE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RSL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RSL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsl_pkg.sv =====
// shared widths, constants and types for the spotlight luminance block
// no dependencies; imported by every rtl module and interface
package rsl_pkg;

    // field widths
    localparam int COORD_W  = 12;
    localparam int CENTER_W = 14;
    localparam int LUM_W    = 16;

    // default largest image dimension; coordinates at or above it saturate
    localparam int MAX_DIMENSION = 4096;

    // distance path widths
    localparam int DIFF_W = CENTER_W + 1;        // signed centre minus coordinate
    localparam int ABS_W  = CENTER_W;            // magnitude of the difference
    localparam int SQ_W   = 2 * ABS_W;
    localparam int D2_W   = SQ_W + 1;

    // distance in Q.8, far limit and slope
    localparam int DIST_FRAC  = 8;
    localparam int FAR_DIST   = 160;
    localparam int SLOPE_DIST = 200;
    localparam logic [D2_W-1:0] FAR_D2 = D2_W'(FAR_DIST * FAR_DIST);
    localparam int NEAR_W = 15;                  // bits of a squared distance below the limit

    // square root of the near squared distance shifted up by 2*DIST_FRAC
    localparam int ROOT_W          = 16;
    localparam int RAD_W           = 2 * ROOT_W;
    localparam int REM_W           = ROOT_W + 2;
    localparam int SQRT_STAGES     = 4;
    localparam int STEPS_PER_STAGE = ROOT_W / SQRT_STAGES;
    localparam logic [ROOT_W-1:0] FAR_LIMIT_Q8 = ROOT_W'(FAR_DIST << DIST_FRAC);

    // scale factor over SLOPE_DEN; far factor of 0.2 written over the same denominator
    localparam int FACTOR_W = 16;
    localparam logic [FACTOR_W-1:0] SLOPE_DEN  = FACTOR_W'(SLOPE_DIST << DIST_FRAC);
    localparam logic [FACTOR_W-1:0] FAR_FACTOR = FACTOR_W'((SLOPE_DIST << DIST_FRAC) / 5);

    // division by SLOPE_DEN = 2^11 * 25: shift, then reciprocal multiply by 25
    localparam int PROD_W    = LUM_W + FACTOR_W;
    localparam int DEN_SHIFT = 11;
    localparam int Q_W       = PROD_W - DEN_SHIFT;
    localparam int DIV       = 25;
    localparam int RECIP_K   = 26;
    localparam int RECIP_W   = 22;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((2**RECIP_K) / DIV);
    localparam int EST_W     = Q_W + RECIP_W;

    // register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_SEL = 2;

    typedef enum logic {
        REG_CENTER_COLUMN = 1'b0,
        REG_CENTER_ROW    = 1'b1
    } t_reg_idx;

    // spotlight centre handed from the register block to the datapath
    typedef struct packed {
        logic signed [CENTER_W-1:0] center_column;
        logic signed [CENTER_W-1:0] center_row;
    } t_centre;

endpackage

// ===== rtl/rsl_pix_if.sv =====
// input channel of the spotlight block: pixel position and luminance
// depends on rsl_pkg for field widths
interface rsl_pix_if
    import rsl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;
    logic [LUM_W-1:0]   luminance_in;

    modport source (output valid, output pixel_column, output pixel_row,
                    output luminance_in, input ready);
    modport sink   (input valid, input pixel_column, input pixel_row,
                    input luminance_in, output ready);
endinterface

// ===== rtl/rsl_lum_if.sv =====
// output channel of the spotlight block: scaled luminance
// depends on rsl_pkg for field widths
interface rsl_lum_if
    import rsl_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LUM_W-1:0] luminance_out;

    modport source (output valid, output luminance_out, input ready);
    modport sink   (input valid, input luminance_out, output ready);
endinterface

// ===== rtl/rsl_apb_regs.sv =====
// apb register block holding the spotlight centre
// depends on rsl_pkg for the register map and the centre struct
module rsl_apb_regs
    import rsl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_centre            o_centre
);

    t_centre  r_centre;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[REG_SEL]);
    assign w_wr     = psel && penable && pwrite;
    assign o_centre = r_centre;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CENTER_COLUMN: r_centre.center_column <= pwdata[CENTER_W-1:0];
                REG_CENTER_ROW:    r_centre.center_row    <= pwdata[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    // read back, sign extended
    always_comb begin
        unique case (w_idx)
            REG_CENTER_COLUMN: prdata = PDATA_W'(r_centre.center_column);
            REG_CENTER_ROW:    prdata = PDATA_W'(r_centre.center_row);
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== rtl/rsl_sqrt_step.sv =====
// STEPS_PER_STAGE digit steps of a restoring integer square root, two radicand bits a step
// depends on rsl_pkg for widths and the step count
module rsl_sqrt_step
    import rsl_pkg::*;
(
    input  logic [ROOT_W-1:0] i_root,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root,
    output logic [REM_W-1:0]  o_rem,
    output logic [RAD_W-1:0]  o_rad
);

    always_comb begin
        logic [ROOT_W-1:0]  root_v;
        logic [REM_W-1:0]   rem_v;
        logic [RAD_W-1:0]   rad_v;
        logic [REM_W+1:0]   cur;
        logic [REM_W+1:0]   trial;
        root_v = i_root;
        rem_v  = i_rem;
        rad_v  = i_rad;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            // bring down the next pair and try the next root bit
            cur   = {rem_v, rad_v[RAD_W-1 -: 2]};
            trial = (REM_W + 2)'({root_v, 2'b01});
            if (cur >= trial) begin
                rem_v  = REM_W'(cur - trial);
                root_v = {root_v[ROOT_W-2:0], 1'b1};
            end else begin
                rem_v  = REM_W'(cur);
                root_v = {root_v[ROOT_W-2:0], 1'b0};
            end
            rad_v = {rad_v[RAD_W-3:0], 2'b00};
        end
        o_root = root_v;
        o_rem  = rem_v;
        o_rad  = rad_v;
    end

endmodule

// ===== rtl/radial_spotlight_luminance.sv =====
// top level of the spotlight luminance block: distance, square root, scaling
// depends on rsl_pkg, rsl_pix_if, rsl_lum_if, rsl_apb_regs and rsl_sqrt_step
//
// Takes one pixel per clock while the output is not held off and returns one
// scaled luminance per pixel, in order, through these register stages: three
// that form the distance magnitudes, their squares and the squared distance;
// four of the square root, each settling four bits of the Q.8 distance; and
// four that form the scale factor, multiply, and divide by 51200 through a
// shift and a reciprocal multiply with a one-step correction. Every stage
// moves on its own when the one after it has room, so an empty slot is filled
// while a result waits. Within 160 pixels of the centre the luminance is
// scaled by 1 - 0.005 * distance, beyond it by 0.2, rounded down. Pixel
// coordinates at or above P_MAX_DIMENSION saturate to one below it. Registers:
// centre column at byte address 0 and centre row at 4, both 14-bit signed,
// reset to zero, to be written only while the block holds no item.
module radial_spotlight_luminance
    import rsl_pkg::*;
#(
    parameter int P_MAX_DIMENSION = MAX_DIMENSION
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    rsl_pix_if.sink            i_pix,
    rsl_lum_if.source          o_lum
);

`include "radial_spotlight_luminance_assert.svh"

    // stage positions
    localparam int ST_ABS   = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_ROOT0 = 3;
    localparam int ST_ROOTN = ST_ROOT0 + SQRT_STAGES - 1;
    localparam int ST_FAC   = ST_ROOTN + 1;
    localparam int ST_PROD  = ST_FAC + 1;
    localparam int ST_EST   = ST_PROD + 1;
    localparam int ST_OUT   = ST_EST + 1;
    localparam int N_ST     = ST_OUT + 1;

    // coordinate saturation limit, never above the field's range
    localparam int COORD_LIM_I = (P_MAX_DIMENSION - 1 > (2**COORD_W) - 1) ?
                                 (2**COORD_W) - 1 : P_MAX_DIMENSION - 1;
    localparam logic [COORD_W-1:0] COORD_LIM = COORD_LIM_I[COORD_W-1:0];

    t_centre w_centre;

    // configuration registers
    rsl_apb_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_centre (w_centre)
    );

    // valid bits and per-stage advance
    logic [N_ST-1:0] r_v;
    logic [N_ST:0]   w_en;

    always_comb begin
        w_en[N_ST] = o_lum.ready;
        for (int k = N_ST - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_pix.ready = w_en[ST_ABS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_pix.valid;
            end
            for (int k = 1; k < N_ST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: clamp coordinates, difference to centre, magnitude
    logic [COORD_W-1:0]       n_col;
    logic [COORD_W-1:0]       n_row;
    logic signed [DIFF_W-1:0] n_dx;
    logic signed [DIFF_W-1:0] n_dy;
    logic [ABS_W-1:0]         n_ax;
    logic [ABS_W-1:0]         n_ay;
    logic [ABS_W-1:0]         r_ax;
    logic [ABS_W-1:0]         r_ay;
    logic [LUM_W-1:0]         r_lum0;

    always_comb begin
        n_col = (i_pix.pixel_column > COORD_LIM) ? COORD_LIM : i_pix.pixel_column;
        n_row = (i_pix.pixel_row > COORD_LIM) ? COORD_LIM : i_pix.pixel_row;
        n_dx  = DIFF_W'(w_centre.center_column) - $signed(DIFF_W'(n_col));
        n_dy  = DIFF_W'(w_centre.center_row) - $signed(DIFF_W'(n_row));
        n_ax  = n_dx[DIFF_W-1] ? ABS_W'(-n_dx) : ABS_W'(n_dx);
        n_ay  = n_dy[DIFF_W-1] ? ABS_W'(-n_dy) : ABS_W'(n_dy);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_ABS]) begin
            r_ax   <= n_ax;
            r_ay   <= n_ay;
            r_lum0 <= i_pix.luminance_in;
        end
    end

    // stage 1: squares
    logic [SQ_W-1:0]  r_sq_x;
    logic [SQ_W-1:0]  r_sq_y;
    logic [LUM_W-1:0] r_lum1;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SQ]) begin
            r_sq_x <= SQ_W'(r_ax) * SQ_W'(r_ax);
            r_sq_y <= SQ_W'(r_ay) * SQ_W'(r_ay);
            r_lum1 <= r_lum0;
        end
    end

    // stage 2: squared distance, far decision, radicand in Q.16
    logic [D2_W-1:0]  n_d2;
    logic [RAD_W-1:0] r_rad2;
    logic             r_far2;
    logic [LUM_W-1:0] r_lum2;

    assign n_d2 = D2_W'(r_sq_x) + D2_W'(r_sq_y);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM]) begin
            r_far2 <= (n_d2 >= FAR_D2);
            r_rad2 <= RAD_W'(n_d2[NEAR_W-1:0]) << (2 * DIST_FRAC);
            r_lum2 <= r_lum1;
        end
    end

    // square root stages
    logic [ROOT_W-1:0] r_root [SQRT_STAGES];
    logic [REM_W-1:0]  r_rem  [SQRT_STAGES];
    logic [RAD_W-1:0]  r_rad  [SQRT_STAGES];
    logic              r_sfar [SQRT_STAGES];
    logic [LUM_W-1:0]  r_slum [SQRT_STAGES];

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
        logic [ROOT_W-1:0] w_root_i;
        logic [REM_W-1:0]  w_rem_i;
        logic [RAD_W-1:0]  w_rad_i;
        logic              w_far_i;
        logic [LUM_W-1:0]  w_lum_i;
        logic [ROOT_W-1:0] w_root_o;
        logic [REM_W-1:0]  w_rem_o;
        logic [RAD_W-1:0]  w_rad_o;

        if (j == 0) begin : g_first
            assign w_root_i = '0;
            assign w_rem_i  = '0;
            assign w_rad_i  = r_rad2;
            assign w_far_i  = r_far2;
            assign w_lum_i  = r_lum2;
        end else begin : g_next
            assign w_root_i = r_root[j-1];
            assign w_rem_i  = r_rem[j-1];
            assign w_rad_i  = r_rad[j-1];
            assign w_far_i  = r_sfar[j-1];
            assign w_lum_i  = r_slum[j-1];
        end

        rsl_sqrt_step u_step (
            .i_root (w_root_i),
            .i_rem  (w_rem_i),
            .i_rad  (w_rad_i),
            .o_root (w_root_o),
            .o_rem  (w_rem_o),
            .o_rad  (w_rad_o)
        );

        always_ff @(posedge i_clk) begin
            if (w_en[ST_ROOT0 + j]) begin
                r_root[j] <= w_root_o;
                r_rem[j]  <= w_rem_o;
                r_rad[j]  <= w_rad_o;
                r_sfar[j] <= w_far_i;
                r_slum[j] <= w_lum_i;
            end
        end
    end

    // scale factor over SLOPE_DEN
    logic [FACTOR_W-1:0] r_fac;
    logic [LUM_W-1:0]    r_flum;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_FAC]) begin
            r_fac  <= r_sfar[SQRT_STAGES-1] ? FAR_FACTOR
                                            : SLOPE_DEN - r_root[SQRT_STAGES-1];
            r_flum <= r_slum[SQRT_STAGES-1];
        end
    end

    // luminance times factor
    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PROD]) begin
            r_prod <= PROD_W'(r_flum) * PROD_W'(r_fac);
        end
    end

    // quotient estimate by 25 through the reciprocal
    logic [Q_W-1:0]   w_q;
    logic [EST_W-1:0] w_est_prod;
    logic [Q_W-1:0]   r_q;
    logic [LUM_W-1:0] r_est;

    assign w_q        = r_prod[PROD_W-1:DEN_SHIFT];
    assign w_est_prod = EST_W'(w_q) * EST_W'(RECIP_M);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_EST]) begin
            r_q   <= w_q;
            r_est <= w_est_prod[RECIP_K +: LUM_W];
        end
    end

    // correction: the estimate is at most one short
    logic [Q_W-1:0]   w_est_rem;
    logic [LUM_W-1:0] r_out;

    assign w_est_rem = r_q - Q_W'(r_est) * Q_W'(DIV);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_out <= (w_est_rem >= Q_W'(DIV)) ? r_est + LUM_W'(1) : r_est;
        end
    end

    assign o_lum.valid         = r_v[ST_OUT];
    assign o_lum.luminance_out = r_out;

    // checks
    `RSL_ASSERT_IMP(a_near_root, i_clk, i_rst_n,
        r_v[ST_ROOTN] && !r_sfar[SQRT_STAGES-1],
        r_root[SQRT_STAGES-1] < FAR_LIMIT_Q8, "near distance reached the far limit")
    `RSL_ASSERT_IMP(a_est_one_short, i_clk, i_rst_n,
        r_v[ST_OUT - 1] && w_en[ST_OUT],
        w_est_rem < Q_W'(2 * DIV), "reciprocal estimate off by more than one")
    `RSL_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n,
        !i_pix.ready, (&r_v) && !o_lum.ready, "input held off with room in the pipeline")
    `RSL_ASSERT_NXT(a_out_moves, i_clk, i_rst_n,
        r_v[ST_OUT] && o_lum.ready && !r_v[ST_EST], !r_v[ST_OUT],
        "delivered item shown again")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for radial_spotlight_luminance: queued pixel items, predicted luminance
// depends on rsl_pkg, rsl_pix_if, rsl_lum_if and the block's rtl
module tb_top;
    import rsl_pkg::*;

    localparam int IDLE_PCT     = 32;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 200;
    localparam int NEAR_Q8      = 160 << 8;
    localparam int SLOPE_Q8     = 200 << 8;
    localparam int FAR_DIV      = 5;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [LUM_W-1:0]   lum;
    } t_pixel;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    rsl_pix_if pix_ch ();
    rsl_lum_if lum_ch ();

    radial_spotlight_luminance DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_ch),
        .o_lum   (lum_ch)
    );

    // pixels waiting to be offered, luminances still owed by the block
    t_pixel           pixel_backlog[$];
    logic [LUM_W-1:0] lum_expected[$];

    // bench copy of the centre registers
    logic signed [CENTER_W-1:0] centre_col = '0;
    logic signed [CENTER_W-1:0] centre_row = '0;

    int   error_count = 0;
    int   hold_req    = 0;
    int   hold_seen   = 0;
    int   stall_left  = 0;
    int   quiet_count = 0;
    logic steady      = 1'b0;

    always #4 i_clk = ~i_clk;

    // spotlight falloff: distance in q.8, linear fade inside 160 pixels, fifth beyond
    function automatic logic [LUM_W-1:0] spotlight_lum(
        input logic signed [CENTER_W-1:0] cc,
        input logic signed [CENTER_W-1:0] cr,
        input logic [COORD_W-1:0]         col,
        input logic [COORD_W-1:0]         row,
        input logic [LUM_W-1:0]           lum
    );
        longint          px;
        longint          py;
        longint          dx;
        longint          dy;
        longint unsigned d2;
        longint unsigned rad;
        longint unsigned root;
        longint unsigned probe;
        longint unsigned scaled;
        px = (col >= MAX_DIMENSION) ? MAX_DIMENSION - 1 : longint'(col);
        py = (row >= MAX_DIMENSION) ? MAX_DIMENSION - 1 : longint'(row);
        dx = longint'(cc) - px;
        dy = longint'(cr) - py;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        d2 = dx * dx + dy * dy;
        // bitwise integer square root of d2 scaled by 2^16
        rad   = d2 << 16;
        root  = 0;
        probe = 64'h1 << 62;
        while (probe > rad)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rad >= root + probe) begin
                rad  = rad - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        if (root < NEAR_Q8)
            scaled = (longint'(lum) * (SLOPE_Q8 - root)) / SLOPE_Q8;
        else
            scaled = longint'(lum) / FAR_DIV;
        return scaled[LUM_W-1:0];
    endfunction

    // random coordinate within 170 pixels of a centre, kept inside the image
    function automatic logic [COORD_W-1:0] coord_near(input int centre);
        int c;
        c = centre + int'($urandom_range(0, 340)) - 170;
        if (c < 0) c = 0;
        if (c > (1 << COORD_W) - 1) c = (1 << COORD_W) - 1;
        return COORD_W'(c);
    endfunction

    function automatic logic [LUM_W-1:0] random_lum();
        logic [LUM_W-1:0] picks[4];
        picks = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE};
        if ($urandom_range(0, 99) < 20)
            return picks[$urandom_range(0, 3)];
        return LUM_W'($urandom);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic queue_pixel(input int col, input int row, input int lum);
        t_pixel p;
        p.col = COORD_W'(col);
        p.row = COORD_W'(row);
        p.lum = LUM_W'(lum);
        pixel_backlog.push_back(p);
    endtask

    // wait until nothing is queued, offered or owed
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_backlog.size() != 0 || pix_ch.valid || lum_expected.size() != 0);
    endtask

    // apb write: setup cycle, access cycle, then release
    task automatic write_centre(input t_reg_idx idx, input logic signed [CENTER_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER_COLUMN: centre_col = val;
            REG_CENTER_ROW:    centre_row = val;
        endcase
    endtask

    // driver: offers backlog items, predicts each accepted item
    always @(posedge i_clk) begin : drive_pixels
        logic   offer;
        t_pixel nxt;
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready)
                lum_expected.push_back(spotlight_lum(centre_col, centre_row,
                    pix_ch.pixel_column, pix_ch.pixel_row, pix_ch.luminance_in));
            if (!(pix_ch.valid && !pix_ch.ready)) begin
                offer = pixel_backlog.size() != 0 &&
                        (steady || $urandom_range(0, 99) >= IDLE_PCT);
                if (offer) begin
                    nxt = pixel_backlog.pop_front();
                    pix_ch.pixel_column <= nxt.col;
                    pix_ch.pixel_row    <= nxt.row;
                    pix_ch.luminance_in <= nxt.lum;
                end
                pix_ch.valid <= offer;
            end
        end
    end

    // monitor: checks each accepted luminance, drives ready with stalls and long holds
    always @(posedge i_clk) begin : check_results
        logic [LUM_W-1:0] want;
        if (!i_rst_n) begin
            lum_ch.ready <= 1'b0;
        end else begin
            if (lum_ch.valid && lum_ch.ready) begin
                if (lum_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected luminance %0d", lum_ch.luminance_out));
                end else begin
                    want = lum_expected.pop_front();
                    if (lum_ch.luminance_out !== want)
                        report_mismatch($sformatf("luminance_out %0d, predicted %0d",
                                                  lum_ch.luminance_out, want));
                end
            end
            if (hold_seen != hold_req) begin
                hold_seen  = hold_req;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left != 0) begin
                stall_left--;
                lum_ch.ready <= 1'b0;
            end else begin
                lum_ch.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (lum_ch.valid && lum_ch.ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus: directed pixels at the reset centre, then phases of random pixels
    initial begin
        int cols[8];
        int rows[8];
        int cc;
        int cr;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        pix_ch.valid        = 1'b0;
        pix_ch.pixel_column = '0;
        pix_ch.pixel_row    = '0;
        pix_ch.luminance_in = '0;
        lum_ch.ready        = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // centre at origin: zero distance, both sides of the 160 limit, far corner
        queue_pixel(0, 0, 65535);
        queue_pixel(0, 0, 0);
        queue_pixel(0, 0, 1);
        queue_pixel(159, 0, 65535);
        queue_pixel(160, 0, 65535);
        queue_pixel(96, 128, 65535);
        queue_pixel(95, 128, 65535);
        queue_pixel(1, 1, 65535);
        queue_pixel(0, 159, 12345);
        queue_pixel(113, 113, 43690);
        queue_pixel(4095, 4095, 65535);
        queue_pixel(4095, 0, 21845);
        queue_pixel(0, 4095, 65534);
        queue_pixel(2730, 1365, 65535);

        // centres: fixed ones at edges of the 14-bit range, mid-image and an image edge, then random ones
        cols = '{-4096, 8191, 2048, 0, -8192, 0, 0, 0};
        rows = '{8191, -4096, 2048, 4095, 8191, 0, 0, 0};
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            steady = 1'b0;
            if (ph >= 5) begin
                cols[ph] = int'($urandom_range(0, 12287)) - 4096;
                rows[ph] = int'($urandom_range(0, 12287)) - 4096;
                if (ph == 5) begin
                    cols[ph] = int'($urandom_range(0, 4095));
                    rows[ph] = int'($urandom_range(0, 4095));
                end
            end
            write_centre(REG_CENTER_COLUMN, CENTER_W'(cols[ph]));
            write_centre(REG_CENTER_ROW, CENTER_W'(rows[ph]));
            @(negedge i_clk);
            if (ph == 2)
                hold_req++;
            steady = (ph == 4);
            cc = cols[ph];
            cr = rows[ph];
            queue_pixel(0, 0, 65535);
            queue_pixel(4095, 4095, 65535);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // half the pixels near the centre so the fade region is well covered
                if ($urandom_range(0, 1) == 0)
                    queue_pixel(coord_near(cc), coord_near(cr), random_lum());
                else
                    queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), random_lum());
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
